// ===== hdl/trs_pkg.sv =====
// Package for the random tour search block: sizes, codes and the
// command and status bundles between its controller and datapath.
// It depends on nothing; every other file uses it by scoped names.
`default_nettype none
package trs_pkg;
  localparam int MAX_CITIES = 16;
  localparam int CITY_W     = $clog2(MAX_CITIES);
  localparam int CNT_W      = CITY_W + 1;
  localparam int DIST_W     = 16;
  localparam int COST_W     = 20;
  localparam int ACC_W      = DIST_W + CITY_W + 1;
  localparam int ITER_W     = 20;
  localparam int SEED_W     = 32;
  localparam int DRAW_W     = 15;
  localparam int MODC_W     = $clog2(DRAW_W);
  localparam int ADDR_W     = 2 * CITY_W;
  localparam int DEPTH      = MAX_CITIES * MAX_CITIES;
  localparam int IN_W       = 2 * CITY_W + DIST_W;
  localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = COST_W + CITY_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SEED_W;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [CNT_W-1:0]  CITY_COUNT_RESET = CNT_W'(16);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1000);
  localparam logic [SEED_W-1:0] SEED_RESET = SEED_W'(1);
  localparam logic [COST_W-1:0] COST_ONES = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CITY_COUNT = 2'd0,
    CFG_ITERATIONS = 2'd1,
    CFG_SEED       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic load_table;
    logic init;
    logic load_i;
    logic draw;
    logic mod_step;
    logic swap_rd;
    logic swap_wr;
    logic cost_start;
    logic cost_step;
    logic compare;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic shuffle_done;
    logic mod_done;
    logic cost_last;
    logic emit_last;
  } sts_t;
endpackage
`default_nettype wire

// ===== hdl/trs_ctrl.sv =====
// Controller of the random tour search: sequences shuffle, cost and emit.
// It depends on trs_pkg and drives trs_datapath through command signals.
`default_nettype none
module trs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_op,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire trs_pkg::sts_t sts,
  output trs_pkg::cmd_t      cmd
);
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_NEXT  = 11'b000_0000_0010,
    ST_SHUF  = 11'b000_0000_0100,
    ST_MOD   = 11'b000_0000_1000,
    ST_SWRD  = 11'b000_0001_0000,
    ST_SWWR  = 11'b000_0010_0000,
    ST_COST  = 11'b000_0100_0000,
    ST_DRAIN = 11'b000_1000_0000,
    ST_CMP   = 11'b001_0000_0000,
    ST_EMIT  = 11'b010_0000_0000,
    ST_SPARE = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_op == trs_pkg::OP_START) begin
            cmd.init   = 1'b1;
            state_next = ST_NEXT;
          end else begin
            cmd.load_table = 1'b1;
          end
        end
      end
      ST_NEXT: begin
        if (sts.iter_done) begin
          state_next = ST_EMIT;
        end else begin
          cmd.load_i = 1'b1;
          state_next = ST_SHUF;
        end
      end
      ST_SHUF: begin
        if (sts.shuffle_done) begin
          cmd.cost_start = 1'b1;
          state_next     = ST_COST;
        end else begin
          cmd.draw   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_next = ST_SWRD;
        end
      end
      ST_SWRD: begin
        cmd.swap_rd = 1'b1;
        state_next  = ST_SWWR;
      end
      ST_SWWR: begin
        cmd.swap_wr = 1'b1;
        state_next  = ST_SHUF;
      end
      ST_COST: begin
        cmd.cost_step = 1'b1;
        if (sts.cost_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = ST_NEXT;
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/trs_datapath.sv =====
// Datapath of the random tour search: configuration, generator, modulo unit,
// tours, distance memory and cost accumulator. It depends on trs_pkg.
`default_nettype none
module trs_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [trs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [trs_pkg::IN_BYTES_W-1:0]   s_tdata,
  input  wire trs_pkg::cmd_t                    cmd,
  output trs_pkg::sts_t                         sts,
  output logic [trs_pkg::OUT_BYTES_W-1:0]       m_tdata
);
  localparam int CW = trs_pkg::CITY_W;

  logic [trs_pkg::CNT_W-1:0]  city_count;
  logic [trs_pkg::ITER_W-1:0] search_iterations;
  logic [trs_pkg::SEED_W-1:0] lfsr, lfsr_next;

  logic [trs_pkg::CNT_W-1:0]  n, n_next;
  logic [trs_pkg::ITER_W-1:0] iter;
  logic [CW-1:0]              idx_i, idx_j, tmp, emit_idx, col, prev;
  logic [trs_pkg::DRAW_W-1:0] dvd;
  logic [CW-1:0]              rem;
  logic [CW:0]                rem_try;
  logic [trs_pkg::MODC_W-1:0] mcnt;
  logic [CW-1:0]              tour [trs_pkg::MAX_CITIES];
  logic [CW-1:0]              best [trs_pkg::MAX_CITIES];
  logic [trs_pkg::COST_W-1:0] best_cost, cost_sat;
  logic [trs_pkg::ACC_W-1:0]  acc;
  logic [trs_pkg::CNT_W-1:0]  k;
  logic                       rd_vld;
  logic [trs_pkg::DIST_W-1:0] mem [trs_pkg::DEPTH];
  logic [trs_pkg::DIST_W-1:0] rdata;
  logic [trs_pkg::ADDR_W-1:0] wr_addr, rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count        <= trs_pkg::CITY_COUNT_RESET;
      search_iterations <= trs_pkg::ITER_RESET;
      lfsr              <= trs_pkg::SEED_RESET;
    end else if (cfg_we) begin
      if (cfg_index == trs_pkg::CFG_CITY_COUNT) begin
        city_count <= cfg_data[trs_pkg::CNT_W-1:0];
      end else if (cfg_index == trs_pkg::CFG_ITERATIONS) begin
        search_iterations <= cfg_data[trs_pkg::ITER_W-1:0];
      end else if (cfg_index == trs_pkg::CFG_SEED) begin
        lfsr <= cfg_data[trs_pkg::SEED_W-1:0];
      end
    end else if (cmd.draw) begin
      lfsr <= lfsr_next;
    end
  end

  always_comb begin
    lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? trs_pkg::LFSR_TAPS : '0);
    if (city_count < trs_pkg::CNT_W'(2)) begin
      n_next = trs_pkg::CNT_W'(2);
    end else if (city_count > trs_pkg::CNT_W'(trs_pkg::MAX_CITIES)) begin
      n_next = trs_pkg::CNT_W'(trs_pkg::MAX_CITIES);
    end else begin
      n_next = city_count;
    end
    rem_try  = {rem, dvd[trs_pkg::DRAW_W-1]};
    idx_j    = rem + CW'(1);
    col      = (k == n) ? '0 : tour[k[CW-1:0]];
    wr_addr  = s_tdata[trs_pkg::ADDR_W-1:0];
    rd_addr  = {prev, col};
    cost_sat = (acc > trs_pkg::ACC_W'(trs_pkg::COST_ONES)) ? trs_pkg::COST_ONES
                                                           : acc[trs_pkg::COST_W-1:0];
    sts.iter_done    = (iter == search_iterations);
    sts.shuffle_done = (idx_i < CW'(2));
    sts.mod_done     = (mcnt == trs_pkg::MODC_W'(trs_pkg::DRAW_W - 1));
    sts.cost_last    = (k == n);
    sts.emit_last    = ({1'b0, emit_idx} == n - trs_pkg::CNT_W'(1));
    m_tdata = trs_pkg::OUT_BYTES_W'({best[emit_idx], best_cost});
  end

  // Write item stores row from_city, column to_city.
  always_ff @(posedge clk) begin
    if (cmd.load_table) begin
      mem[{wr_addr[CW-1:0], wr_addr[trs_pkg::ADDR_W-1:CW]}] <=
        s_tdata[trs_pkg::ADDR_W +: trs_pkg::DIST_W];
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int c = 0; c < trs_pkg::MAX_CITIES; c++) begin
        tour[c] <= CW'(c);
        best[c] <= CW'(c);
      end
      best_cost <= trs_pkg::COST_ONES;
      iter      <= '0;
      n         <= n_next;
      emit_idx  <= '0;
    end
    if (cmd.load_i) begin
      idx_i <= CW'(n - trs_pkg::CNT_W'(1));
    end
    if (cmd.draw) begin
      dvd  <= lfsr_next[trs_pkg::DRAW_W-1:0];
      rem  <= '0;
      mcnt <= '0;
    end
    if (cmd.mod_step) begin
      if (rem_try >= {1'b0, idx_i}) begin
        rem <= CW'(rem_try - {1'b0, idx_i});
      end else begin
        rem <= rem_try[CW-1:0];
      end
      dvd  <= dvd << 1;
      mcnt <= mcnt + trs_pkg::MODC_W'(1);
    end
    if (cmd.swap_rd) begin
      tmp <= tour[idx_i];
    end
    if (cmd.swap_wr) begin
      tour[idx_i] <= tour[idx_j];
      tour[idx_j] <= tmp;
      idx_i       <= idx_i - CW'(1);
    end
    if (cmd.cost_start) begin
      k    <= trs_pkg::CNT_W'(1);
      prev <= '0;
      acc  <= '0;
    end else if (rd_vld) begin
      acc <= acc + trs_pkg::ACC_W'(rdata);
    end
    if (cmd.cost_step) begin
      prev <= col;
      k    <= k + trs_pkg::CNT_W'(1);
    end
    if (cmd.compare) begin
      if (cost_sat < best_cost) begin
        best_cost <= cost_sat;
        for (int c = 0; c < trs_pkg::MAX_CITIES; c++) begin
          best[c] <= tour[c];
        end
      end
      iter <= iter + trs_pkg::ITER_W'(1);
    end
    if (cmd.emit_step) begin
      emit_idx <= emit_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.cost_step;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tour_random_search.sv =====
// Random search for the asymmetric travelling salesman problem, top level.
// It depends on trs_pkg, trs_ctrl and trs_datapath.
//
// Input items on the s_ channel: tuser is the operation. A write item
// (operation 0) stores one entry of the directed distance table; write
// items may follow each other in every cycle while the block is idle.
// A start item (operation 1) runs search_iterations random shuffles of the
// running tour and then emits the best tour on the m_ channel, one item per
// city, with the best cost in every item and tlast on the final city.
// In each iteration, every swap draws from the generator, runs a
// bit-serial modulo unit over the 15-bit draw and reads and then writes
// the tour entries; the cost pass reads the distance memory once per
// tour edge through its single registered read port.
// While a search runs or results are pending, s_tready is low; a stall on
// m_tready holds the current item until taken. Configuration writes on
// cfg_we, cfg_index and cfg_data apply at once; writing the seed reloads
// the generator.
// Synchronous reset restores the configuration defaults and returns to idle;
// the distance table is not cleared.
`default_nettype none
module tour_random_search (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [trs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [trs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // from_city [3:0], to_city [7:4], distance [23:8]
  input  wire logic [trs_pkg::IN_BYTES_W-1:0]  s_tdata,
  // operation [0]
  input  wire logic                            s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // best_cost [19:0], tour_city [23:20]
  output logic [trs_pkg::OUT_BYTES_W-1:0]      m_tdata,
  output logic                                 m_tlast
);
  trs_pkg::cmd_t cmd;
  trs_pkg::sts_t sts;

  trs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata)
  );

  assign m_tlast = sts.emit_last;

  a_idle_no_output: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("output valid while accepting input");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == trs_pkg::OP_START) |=> !s_tready)
    else $error("input accepted during a search");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == trs_pkg::OP_WRITE) |=> s_tready)
    else $error("table write left the idle state");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("no return to idle after the final city");
endmodule
`default_nettype wire

// ===== bench/tb_tour_random_search.sv =====
// Self-checking bench for the random tour search block: it loads the distance
// table, runs searches under several register settings and checks every tour
// item. It depends on trs_pkg and tour_random_search.
`timescale 1ns / 100ps
`default_nettype none
module tb_tour_random_search;

  typedef struct packed {
    logic [trs_pkg::COST_W-1:0] cost;
    logic [trs_pkg::CITY_W-1:0] city;
    logic                       last;
  } tour_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [trs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [trs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [trs_pkg::IN_BYTES_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [trs_pkg::OUT_BYTES_W-1:0] m_tdata;
  logic m_tlast;

  tour_random_search uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the block state used to predict each search.
  logic [trs_pkg::DIST_W-1:0] dist_copy [trs_pkg::DEPTH];
  logic [trs_pkg::CITY_W-1:0] walk [trs_pkg::MAX_CITIES];
  logic [trs_pkg::CITY_W-1:0] best_walk [trs_pkg::MAX_CITIES];
  logic [trs_pkg::CNT_W-1:0] n_cities = trs_pkg::CITY_COUNT_RESET;
  logic [trs_pkg::ITER_W-1:0] n_iters = trs_pkg::ITER_RESET;
  logic [trs_pkg::SEED_W-1:0] lfsr = trs_pkg::SEED_RESET;

  tour_item_t tour_queue [$];
  int errors = 0;
  int items_sent = 0;
  int searches = 0;
  int tour_items_seen = 0;
  int burst_left = 0;
  int hold_left = 0;
  logic [7:0] ready_mask = 8'hFF;
  int mask_pos = 0;

  function automatic logic [trs_pkg::DRAW_W-1:0] lfsr_draw();
    logic out_bit;
    out_bit = lfsr[0];
    lfsr = lfsr >> 1;
    if (out_bit) lfsr = lfsr ^ trs_pkg::LFSR_TAPS;
    return lfsr[trs_pkg::DRAW_W-1:0];
  endfunction

  function automatic void predict_search();
    int n, i, j, it;
    logic [trs_pkg::CITY_W-1:0] t;
    logic [63:0] sum;
    logic [trs_pkg::COST_W-1:0] best_cost, cost;
    tour_item_t e;
    n = n_cities;
    if (n < 2) n = 2;
    if (n > trs_pkg::MAX_CITIES) n = trs_pkg::MAX_CITIES;
    for (i = 0; i < trs_pkg::MAX_CITIES; i++) begin
      walk[i] = trs_pkg::CITY_W'(i);
      best_walk[i] = trs_pkg::CITY_W'(i);
    end
    best_cost = trs_pkg::COST_ONES;
    for (it = 0; it < n_iters; it++) begin
      for (i = n - 1; i > 1; i--) begin
        j = 1 + int'(lfsr_draw()) % i;
        t = walk[i];
        walk[i] = walk[j];
        walk[j] = t;
      end
      sum = 0;
      for (i = 0; i < n; i++)
        sum += dist_copy[{walk[i], walk[(i + 1) % n]}];
      cost = (sum > trs_pkg::COST_ONES) ? trs_pkg::COST_ONES : trs_pkg::COST_W'(sum);
      if (cost < best_cost) begin
        best_cost = cost;
        best_walk = walk;
      end
    end
    for (i = 0; i < n; i++) begin
      e.cost = best_cost;
      e.city = best_walk[i];
      e.last = (i == n - 1);
      tour_queue.push_back(e);
    end
  endfunction

  task automatic send_item(input logic op, input logic [trs_pkg::CITY_W-1:0] from_c,
                           input logic [trs_pkg::CITY_W-1:0] to_c,
                           input logic [trs_pkg::DIST_W-1:0] dist_val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {dist_val, to_c, from_c};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (op == trs_pkg::OP_WRITE) dist_copy[{from_c, to_c}] = dist_val;
    else begin
      searches++;
      predict_search();
    end
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (burst_left != 0) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
    end
    while (tour_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input trs_pkg::cfg_idx_t idx,
                           input logic [trs_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      trs_pkg::CFG_CITY_COUNT: n_cities = value[trs_pkg::CNT_W-1:0];
      trs_pkg::CFG_ITERATIONS: n_iters = value[trs_pkg::ITER_W-1:0];
      trs_pkg::CFG_SEED: lfsr = value;
      default: ;
    endcase
  endtask

  task automatic run_search(input int cities, input int iters);
    wait_idle();
    write_reg(trs_pkg::CFG_CITY_COUNT, trs_pkg::CFG_DATA_W'(cities));
    write_reg(trs_pkg::CFG_ITERATIONS, trs_pkg::CFG_DATA_W'(iters));
    send_item(trs_pkg::OP_START, '0, '0, '0);
  endtask

  always @(posedge clk) begin
    tour_item_t got, want;
    if (m_tvalid && m_tready) begin
      tour_items_seen++;
      got.cost = m_tdata[trs_pkg::COST_W-1:0];
      got.city = m_tdata[trs_pkg::COST_W+trs_pkg::CITY_W-1:trs_pkg::COST_W];
      got.last = m_tlast;
      if (tour_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual cost %0d city %0d last %0b",
                 $time, got.cost, got.city, got.last);
      end else begin
        want = tour_queue.pop_front();
        if (got.cost !== want.cost) begin
          errors++;
          $display("%0t: best_cost expected %0d actual %0d", $time, want.cost, got.cost);
        end
        if (got.city !== want.city) begin
          errors++;
          $display("%0t: tour_city expected %0d actual %0d", $time, want.city, got.city);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last_city expected %0b actual %0b", $time, want.last, got.last);
        end
      end
    end
    if (mask_pos == 0) begin
      case ($urandom_range(0, 3))
        0: ready_mask = 8'hFF;
        1: ready_mask = 8'h00;
        default: ready_mask = 8'($urandom);
      endcase
    end
    mask_pos = (mask_pos + 1) % 8;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ready_mask[mask_pos];
    end
  end

  task automatic test_table_load();
    for (int f = 0; f < trs_pkg::MAX_CITIES; f++)
      for (int t = 0; t < trs_pkg::MAX_CITIES; t++)
        send_item(trs_pkg::OP_WRITE, trs_pkg::CITY_W'(f), trs_pkg::CITY_W'(t),
                  trs_pkg::DIST_W'($urandom));
  endtask

  task automatic test_reset_defaults();
    wait_idle();
    write_reg(trs_pkg::CFG_ITERATIONS, trs_pkg::CFG_DATA_W'(3));
    send_item(trs_pkg::OP_START, '0, '0, '0);
  endtask

  task automatic test_special_cases();
    wait_idle();
    for (int f = 0; f < 4; f++)
      for (int t = 0; t < 4; t++)
        send_item(trs_pkg::OP_WRITE, trs_pkg::CITY_W'(f), trs_pkg::CITY_W'(t),
                  (f == t) ? 16'h0000 : 16'hFFFF);
    run_search(4, 5);
    run_search(5, 0);
    run_search(0, 2);
    run_search(1, 2);
    run_search(31, 1);
    run_search(17, 1);
    wait_idle();
    write_reg(trs_pkg::CFG_SEED, trs_pkg::CFG_DATA_W'(0));
    run_search(6, 4);
    wait_idle();
    write_reg(trs_pkg::CFG_SEED, 32'hFFFF_FFFF);
    write_reg(trs_pkg::CFG_ITERATIONS, trs_pkg::CFG_DATA_W'(20'hFFFFF));
    run_search(16, 2);
  endtask

  task automatic test_long_search();
    wait_idle();
    write_reg(trs_pkg::CFG_SEED, trs_pkg::CFG_DATA_W'($urandom | 1));
    run_search(16, 250);
  endtask

  task automatic test_backpressure();
    run_search(16, 2);
    hold_left = 1000;
    for (int k = 0; k < 6; k++)
      send_item(trs_pkg::OP_WRITE, trs_pkg::CITY_W'($urandom_range(0, 15)),
                trs_pkg::CITY_W'($urandom_range(0, 15)), trs_pkg::DIST_W'($urandom));
  endtask

  task automatic test_random_mix();
    int cities;
    logic [trs_pkg::DIST_W-1:0] d;
    while (items_sent < 430) begin
      repeat ($urandom_range(0, 12)) begin
        case ($urandom_range(0, 7))
          0: d = '0;
          1: d = '1;
          default: d = trs_pkg::DIST_W'($urandom);
        endcase
        send_item(trs_pkg::OP_WRITE, trs_pkg::CITY_W'($urandom_range(0, 15)),
                  trs_pkg::CITY_W'($urandom_range(0, 15)), d);
      end
      cities = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 8);
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_reg(trs_pkg::CFG_SEED, trs_pkg::CFG_DATA_W'($urandom));
      end
      run_search(cities, $urandom_range(0, 12));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_reset_defaults();
    test_special_cases();
    test_long_search();
    test_backpressure();
    test_random_mix();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d input items including %0d searches; checked %0d tour items.",
             items_sent, searches, tour_items_seen);
    if (errors == 0 && tour_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
